/* design/fmam_pkg.sv */
package fmam_pkg;

	localparam int unsigned PHASE_BITS_DEF     = 32;
	localparam int unsigned SINE_ADDR_BITS_DEF = 10;

	localparam logic [63:0] SAMPLE_RATE   = 64'd2000000;
	localparam logic [63:0] WIDE_DEV_HZ   = 64'd75000;
	localparam logic [63:0] NARROW_DEV_HZ = 64'd5000;
	localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
	localparam logic [63:0] FULL_CODE     = 64'd127;

	localparam logic [15:0] GAIN_RESET = 16'd14746;

	// clip limit of the gain product, 1.0 in Q29
	localparam logic signed [32:0] AMP_ONE = 33'sd536870912;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;

	localparam logic [1:0] MODE_WFM = 2'd0;
	localparam logic [1:0] MODE_NFM = 2'd1;
	localparam logic [1:0] MODE_AM  = 2'd2;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               buffer_start;
	} smp_t;

	typedef struct packed {
		logic signed [7:0] i_out;
		logic signed [7:0] q_out;
	} iq_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INC,
		ST_ACC,
		ST_OUT
	} fmam_state_t;

	// taylor series denominators (2n)(2n+1)
	function automatic logic [63:0] taylor_div(input logic [63:0] t, input int n);
		logic [63:0] r;
		unique case (n)
			1: r = t / 64'd6;
			2: r = t / 64'd20;
			3: r = t / 64'd42;
			4: r = t / 64'd72;
			5: r = t / 64'd110;
			6: r = t / 64'd156;
			7: r = t / 64'd210;
			8: r = t / 64'd272;
			default: r = t;
		endcase
		return r;
	endfunction

	// quarter-wave entry floor(127*sin(pi/2*k/2^ab)) in Q30 integer math
	function automatic logic [6:0] sine_entry(input logic [31:0] k, input int unsigned ab);
		logic [63:0]        x;
		logic [63:0]        term;
		logic [63:0]        v;
		logic signed [63:0] sum;
		x    = (HALF_PI_Q30 * {32'd0, k}) >> ab;
		term = x;
		sum  = $signed(x);
		for (int n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = taylor_div(term, n);
			if ((n & 1) != 0) begin
				sum = sum - $signed(term);
			end else begin
				sum = sum + $signed(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		v = ($unsigned(sum) * FULL_CODE) >> 30;
		if (v > FULL_CODE) begin
			v = FULL_CODE;
		end
		return v[6:0];
	endfunction

endpackage

/* design/fmam_ram.sv */
module fmam_ram
	import fmam_pkg::*;
#(
	parameter int unsigned WIDTH = PHASE_BITS_DEF,
	parameter int unsigned DEPTH = 1,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* design/fmam_sine_rom.sv */
module fmam_sine_rom
	import fmam_pkg::*;
#(
	parameter int unsigned ADDR_BITS = SINE_ADDR_BITS_DEF,
	localparam int unsigned TAB_N = 1 << ADDR_BITS
) (
	input  logic               clk,
	input  logic [ADDR_BITS:0] addr_a,
	input  logic [ADDR_BITS:0] addr_b,
	output logic [6:0]         data_a,
	output logic [6:0]         data_b
);

	// entries 0..N, the last one being full scale
	logic [6:0] tab [TAB_N+1];

	for (genvar k = 0; k <= TAB_N; k++) begin : g_tab
		if (k == TAB_N) begin : g_top
			assign tab[k] = FULL_CODE[6:0];
		end else begin : g_ent
			assign tab[k] = sine_entry(32'(k), ADDR_BITS);
		end
	end

	always_ff @(posedge clk) begin
		data_a <= tab[addr_a];
		data_b <= tab[addr_b];
	end

endmodule

/* design/fm_am_baseband_modulator_unit.sv */
// Audio to 8-bit I/Q modulator: each sample item (Q1.15) is scaled by the Q2.14 gain and
// clipped to +-1, then either drives I directly (AM, Q = 0) or advances a phase accumulator by
// amplitude times peak deviation (75 kHz or 5 kHz at 2 MS/s) whose sine and cosine come from a
// quarter-wave table. buffer_start clears the phase before its sample. Steps of an item: gain
// product and phase memory read, deviation product, phase write-back with table read, result.
// The phase read-modify-write keeps new items out until an item is through; an untaken result
// holds the last step. Mode and gain must be written only while idle; the block does not enforce it.
module fm_am_baseband_modulator_unit
	import fmam_pkg::*;
#(
	parameter int unsigned PHASE_BITS           = PHASE_BITS_DEF,
	parameter int unsigned SINE_TABLE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  smp_valid,
	output logic                  smp_stall,
	input  smp_t                  smp_data,
	output logic                  iq_valid,
	input  logic                  iq_stall,
	output iq_t                   iq_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int unsigned PB     = PHASE_BITS;
	localparam int unsigned AB     = SINE_TABLE_ADDR_BITS;
	localparam int unsigned INCP_W = 30 + PB;

	localparam logic [63:0] DEVK_W64 =
		((WIDE_DEV_HZ << PHASE_BITS) + SAMPLE_RATE / 2) / SAMPLE_RATE;
	localparam logic [63:0] DEVK_N64 =
		((NARROW_DEV_HZ << PHASE_BITS) + SAMPLE_RATE / 2) / SAMPLE_RATE;
	localparam logic [PB-1:0] DEVK_WIDE   = DEVK_W64[PB-1:0];
	localparam logic [PB-1:0] DEVK_NARROW = DEVK_N64[PB-1:0];

	localparam logic [AB:0]     TAB_N   = {1'b1, {AB{1'b0}}};
	localparam logic [INCP_W-1:0] RND_HALF = INCP_W'(64'd1 << 28);
	localparam logic            PH_ADDR = 1'b0;

	fmam_state_t state_q, state_d;

	logic [1:0]  mode_q;
	logic [15:0] gain_q;

	logic        smp_take;
	logic        ram_we;
	logic        iq_load;
	logic        phase_vld_q;
	logic [PB-1:0] ram_rdata;

	// accept step: gain product and clip
	logic signed [32:0] prod;
	logic [32:0]        prod_abs;
	logic [29:0]        mag_d;
	logic               neg_d;
	logic [29:0]        mag_s1;
	logic               neg_s1;
	logic               bstart_s1;

	// deviation step
	logic [PB-1:0]     devk;
	logic [INCP_W-1:0] inc_prod;
	logic [INCP_W-1:0] inc_rnd;
	logic [PB-1:0]     inc_mag;
	logic [36:0]       am_prod;
	logic [7:0]        am_pos;
	logic [PB-1:0]     phase_s2;
	logic [PB-1:0]     inc_s2;
	logic signed [7:0] am_s2;

	// phase update and table step
	logic [PB-1:0] phase_new;
	logic [AB-1:0] tab_k;
	logic [AB:0]   rom_addr_a;
	logic [AB:0]   rom_addr_b;
	logic [6:0]    rom_a;
	logic [6:0]    rom_b;
	logic [1:0]    quad_s3;

	logic signed [7:0] a_pos;
	logic signed [7:0] b_pos;
	iq_t               iq_d;
	iq_t               iq_q;
	logic              iq_valid_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WFM;
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[1:0];
				CFG_GAIN: gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		smp_stall = 1'b1;
		ram_we    = 1'b0;
		iq_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				smp_stall = 1'b0;
				if (smp_valid) begin
					state_d = ST_INC;
				end
			end
			ST_INC: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				ram_we  = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!iq_valid_q || !iq_stall) begin
					iq_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign smp_take = smp_valid && !smp_stall;

	// gain product and clip to +-1.0
	assign prod     = smp_data.sample * $signed({1'b0, gain_q});
	assign prod_abs = prod[32] ? 33'(-prod) : 33'(prod);

	always_comb begin
		if (prod > AMP_ONE) begin
			mag_d = 30'(AMP_ONE);
			neg_d = 1'b0;
		end else if (prod < -AMP_ONE) begin
			mag_d = 30'(AMP_ONE);
			neg_d = 1'b1;
		end else begin
			mag_d = prod_abs[29:0];
			neg_d = prod[32];
		end
	end

	always_ff @(posedge clk) begin
		if (smp_take) begin
			mag_s1    <= mag_d;
			neg_s1    <= neg_d;
			bstart_s1 <= smp_data.buffer_start;
		end
	end

	// phase memory, read at accept, written back in the update step
	fmam_ram #(
		.WIDTH(PB),
		.DEPTH(1)
	) u_phase_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(PH_ADDR),
		.wdata(phase_new),
		.raddr(PH_ADDR),
		.rdata(ram_rdata)
	);

	// the entry reads as zero until its first write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_vld_q <= 1'b0;
		end else if (ram_we) begin
			phase_vld_q <= 1'b1;
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_WFM: devk = DEVK_WIDE;
			MODE_NFM: devk = DEVK_NARROW;
			default:  devk = '0;
		endcase
	end

	assign inc_prod = {{PB{1'b0}}, mag_s1} * {{30{1'b0}}, devk};
	assign inc_rnd  = inc_prod + RND_HALF;
	assign inc_mag  = inc_rnd[29 +: PB];
	assign am_prod  = {7'd0, mag_s1} * 37'd127;
	assign am_pos   = {1'b0, am_prod[35:29]};

	always_ff @(posedge clk) begin
		if (state_q == ST_INC) begin
			phase_s2 <= (bstart_s1 || !phase_vld_q) ? '0 : ram_rdata;
			inc_s2   <= neg_s1 ? PB'(-inc_mag) : inc_mag;
			am_s2    <= neg_s1 ? $signed(8'(-am_pos)) : $signed(am_pos);
		end
	end

	// phase update wraps modulo a full turn
	assign phase_new  = phase_s2 + inc_s2;
	assign tab_k      = phase_new[PB-3 -: AB];
	assign rom_addr_a = {1'b0, tab_k};
	assign rom_addr_b = TAB_N - {1'b0, tab_k};

	fmam_sine_rom #(
		.ADDR_BITS(AB)
	) u_sine_rom (
		.clk   (clk),
		.addr_a(rom_addr_a),
		.addr_b(rom_addr_b),
		.data_a(rom_a),
		.data_b(rom_b)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			quad_s3 <= phase_new[PB-1 -: 2];
		end
	end

	assign a_pos = $signed({1'b0, rom_a});
	assign b_pos = $signed({1'b0, rom_b});

	always_comb begin
		if (mode_q == MODE_AM) begin
			iq_d.i_out = am_s2;
			iq_d.q_out = '0;
		end else begin
			unique case (quad_s3)
				2'd0: begin
					iq_d.i_out = a_pos;
					iq_d.q_out = b_pos;
				end
				2'd1: begin
					iq_d.i_out = b_pos;
					iq_d.q_out = -a_pos;
				end
				2'd2: begin
					iq_d.i_out = -a_pos;
					iq_d.q_out = -b_pos;
				end
				default: begin
					iq_d.i_out = -b_pos;
					iq_d.q_out = a_pos;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iq_valid_q <= 1'b0;
		end else if (iq_load) begin
			iq_valid_q <= 1'b1;
		end else if (!iq_stall) begin
			iq_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (iq_load) begin
			iq_q <= iq_d;
		end
	end

	assign iq_valid = iq_valid_q;
	assign iq_data  = iq_q;

	a_take_starts: assert property (@(posedge clk) disable iff (!arst_n)
		smp_take |=> state_q == ST_INC)
		else $error("accepted item did not start the sequence");

	a_acc_after_inc: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |-> $past(state_q) == ST_INC)
		else $error("phase write-back without a deviation step");

	a_phase_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACC |=> phase_vld_q)
		else $error("phase entry not marked after write-back");

	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		iq_load |=> iq_valid_q && state_q == ST_IDLE)
		else $error("result not presented after the last step");

endmodule

/* tb/fm_am_baseband_modulator_unit_test.sv */
`timescale 1ns / 1ps

module fm_am_baseband_modulator_unit_test;
	import fmam_pkg::*;

	localparam logic [1:0] MODE_HOLD = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int unsigned TAB_BITS = 10;
	localparam int unsigned TAB_LEN = 1 << TAB_BITS;
	localparam longint unsigned Q30_HALF_PI = 64'd1686629713;
	localparam longint unsigned PEAK_CODE = 64'd127;
	localparam longint unsigned FS_HZ = 64'd2000000;
	localparam longint AMP_LIMIT = 64'sd536870912;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_OFF_CYCLES = 120;

	logic clk;
	logic arst_n;
	logic smp_valid;
	logic smp_stall;
	smp_t smp_data;
	logic iq_valid;
	logic iq_stall;
	iq_t iq_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	fm_am_baseband_modulator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.smp_valid(smp_valid),
		.smp_stall(smp_stall),
		.smp_data(smp_data),
		.iq_valid(iq_valid),
		.iq_stall(iq_stall),
		.iq_data(iq_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// model of the block
	logic [6:0] quarter_sine [0:TAB_LEN];
	logic [1:0] mode_reg;
	logic [15:0] gain_reg;
	logic [31:0] phase_model;

	iq_t pending_iq [$];
	iq_t want;
	int mismatches = 0;
	int idle_cycles = 0;
	bit calm = 0;
	bit jam_request = 0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [6:0] sine_code(input int unsigned k);
		longint unsigned x;
		longint unsigned term;
		longint unsigned v;
		longint sum;
		x = (Q30_HALF_PI * longint'(k)) >> TAB_BITS;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / longint'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (longint'(sum) * PEAK_CODE) >> 30;
		if (v > PEAK_CODE) begin
			v = PEAK_CODE;
		end
		return v[6:0];
	endfunction

	function automatic longint unsigned deviation_step(input logic [1:0] m);
		longint unsigned hz;
		case (m)
			MODE_WFM: hz = 64'd75000;
			MODE_NFM: hz = 64'd5000;
			default: return 0;
		endcase
		return ((hz << 32) + FS_HZ / 2) / FS_HZ;
	endfunction

	// advances the phase model and returns the i/q pair for one sample
	function automatic iq_t modulate(input smp_t s);
		longint amp;
		longint unsigned mag;
		longint unsigned inc;
		logic neg;
		logic [1:0] quad;
		int unsigned k;
		int a;
		int b;
		int iv;
		int qv;
		iq_t r;
		if (s.buffer_start) begin
			phase_model = '0;
		end
		amp = longint'(s.sample) * longint'({48'd0, gain_reg});
		if (amp > AMP_LIMIT) begin
			amp = AMP_LIMIT;
		end
		if (amp < -AMP_LIMIT) begin
			amp = -AMP_LIMIT;
		end
		neg = amp < 0;
		mag = neg ? -amp : amp;
		if (mode_reg == MODE_AM) begin
			iv = int'((mag * PEAK_CODE) >> 29);
			if (neg) begin
				iv = -iv;
			end
			qv = 0;
		end else begin
			inc = (mag * deviation_step(mode_reg) + (64'd1 << 28)) >> 29;
			if (neg) begin
				inc = -inc;
			end
			phase_model = phase_model + inc[31:0];
			quad = phase_model[31:30];
			k = phase_model[29:30-TAB_BITS];
			a = quarter_sine[k];
			b = quarter_sine[TAB_LEN - k];
			case (quad)
				2'd0: begin
					iv = a;
					qv = b;
				end
				2'd1: begin
					iv = b;
					qv = -a;
				end
				2'd2: begin
					iv = -a;
					qv = -b;
				end
				default: begin
					iv = -b;
					qv = a;
				end
			endcase
		end
		r.i_out = iv[7:0];
		r.q_out = qv[7:0];
		return r;
	endfunction

	task automatic send_sample(input logic signed [15:0] value, input logic start);
		smp_t item;
		int gap;
		item.sample = value;
		item.buffer_start = start;
		@(negedge clk);
		if (!calm && $urandom_range(99) < 23) begin
			smp_valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(negedge clk);
		end
		smp_valid <= 1'b1;
		smp_data <= item;
		do @(posedge clk); while (smp_stall);
		pending_iq.push_back(modulate(item));
	endtask

	task automatic drain;
		@(negedge clk);
		smp_valid <= 1'b0;
		while (pending_iq.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MODE) begin
			mode_reg = value[1:0];
		end else if (idx == CFG_GAIN) begin
			gain_reg = value;
		end
	endtask

	function automatic logic signed [15:0] pick_sample;
		case ($urandom_range(9))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($signed($urandom_range(0, 64)) - 32);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_reset_state;
		send_sample(16'sd0, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sd1, 1'b0);
		drain();
	endtask

	task automatic test_gain_clip;
		write_reg(CFG_GAIN, 16'hffff);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(-16'sd1, 1'b1);
		send_sample(16'sd1, 1'b0);
		drain();
	endtask

	task automatic test_narrowband;
		write_reg(CFG_MODE, {14'd0, MODE_NFM});
		write_reg(CFG_GAIN, 16'd16384);
		send_sample(16'sd16384, 1'b0);
		send_sample(-16'sd16384, 1'b0);
		send_sample(16'sh7fff, 1'b1);
		drain();
	endtask

	task automatic test_am;
		write_reg(CFG_MODE, {14'd0, MODE_AM});
		write_reg(CFG_GAIN, 16'hffff);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sd1000, 1'b0);
		send_sample(-16'sd1000, 1'b0);
		drain();
		write_reg(CFG_GAIN, 16'd0);
		send_sample(16'sh7fff, 1'b0);
		drain();
	endtask

	// mode three keeps the phase where it is
	task automatic test_held_phase;
		write_reg(CFG_MODE, {14'd0, MODE_WFM});
		write_reg(CFG_GAIN, 16'd16384);
		send_sample(16'sh7fff, 1'b0);
		drain();
		write_reg(CFG_MODE, {14'd0, MODE_HOLD});
		send_sample(16'sd5000, 1'b0);
		send_sample(16'sh8000, 1'b1);
		drain();
	endtask

	task automatic test_spare_index;
		write_reg(CFG_MODE, {14'd0, MODE_WFM});
		write_reg(CFG_SPARE_LO, 16'hffff);
		write_reg(CFG_SPARE_HI, 16'hffff);
		send_sample(16'sd20000, 1'b0);
		send_sample(-16'sd7, 1'b0);
		drain();
	endtask

	task automatic test_backpressure;
		write_reg(CFG_GAIN, 16'd14746);
		jam_request = 1;
		for (int n = 0; n < 40; n++) begin
			send_sample(pick_sample(), $urandom_range(19) == 0);
		end
		drain();
	endtask

	task automatic test_random;
		logic [15:0] g;
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: g = 16'hffff;
				1: g = 16'd0;
				2: g = 16'd16384;
				default: g = 16'($urandom);
			endcase
			write_reg(CFG_MODE, {14'd0, (p < 4) ? 2'(p) : 2'($urandom_range(3))});
			write_reg(CFG_GAIN, g);
			calm = (p == 4);
			for (int n = 0; n < 160; n++) begin
				send_sample(pick_sample(), $urandom_range(19) == 0);
			end
			drain();
			calm = 0;
		end
	endtask

	initial begin
		iq_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (jam_request) begin
				jam_request = 0;
				for (int n = 0; n < HOLD_OFF_CYCLES; n++) begin
					iq_stall <= 1'b1;
					@(negedge clk);
				end
			end
			iq_stall <= !calm && $urandom_range(99) < 23;
		end
	end

	always @(posedge clk) begin
		if (arst_n && iq_valid && !iq_stall) begin
			if (pending_iq.size() == 0) begin
				$error("unexpected item: i_out %0d q_out %0d", iq_data.i_out, iq_data.q_out);
				mismatches++;
			end else begin
				want = pending_iq.pop_front();
				if (want.i_out !== iq_data.i_out) begin
					$error("i_out: expected %0d, got %0d", want.i_out, iq_data.i_out);
					mismatches++;
				end
				if (want.q_out !== iq_data.q_out) begin
					$error("q_out: expected %0d, got %0d", want.q_out, iq_data.q_out);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((smp_valid && !smp_stall) || (iq_valid && !iq_stall) || cfg_we) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		smp_valid = 1'b0;
		smp_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mode_reg = MODE_WFM;
		gain_reg = GAIN_RESET;
		phase_model = '0;
		for (int k = 0; k < TAB_LEN; k++) begin
			quarter_sine[k] = sine_code(k);
		end
		quarter_sine[TAB_LEN] = 7'd127;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_state();
		test_gain_clip();
		test_narrowband();
		test_am();
		test_held_phase();
		test_spare_index();
		test_backpressure();
		test_random();

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
